// ===== hw/rtl/hbc_pkg.sv =====
package hbc_pkg;

    localparam int SMP_W        = 16;
    localparam int CNT_W        = 16;
    localparam int BW_W         = 8;
    localparam int IDX_OUT_W    = 6;
    localparam int MODE_W       = 2;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;
    localparam int NUM_BINS_DEF = 50;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;
    localparam logic [1:0] REG_BAR  = 2'd2;

    localparam logic signed [SMP_W-1:0] LOW_RST  = 16'sd0;
    localparam logic signed [SMP_W-1:0] HIGH_RST = 16'sd25344;
    localparam logic [BW_W-1:0]         BAR_RST  = 8'd60;

endpackage

// ===== hw/rtl/histogram_bin_counter.sv =====
// add sample: out of range only counts in idle; equal bounds skip to the read
// and update of the first bin; else multiply and divide come before the update
// clear and unused mode: no result
// readout: per bin read, multiply, divide and load, bins in rising order, NUM_BINS results
// the bit-serial divider, shared by add and readout, gives one quotient bit per cycle
// reset clears all counters at once through per-bin valid bits, no clearing pass
module histogram_bin_counter #(
    parameter int NUM_BINS = hbc_pkg::NUM_BINS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hbc_pkg::MODE_W-1:0]          mode,
    input  logic signed [hbc_pkg::SMP_W-1:0]    sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hbc_pkg::IDX_OUT_W-1:0]       bin_index,
    output logic [hbc_pkg::CNT_W-1:0]           bin_count,
    output logic [hbc_pkg::BW_W-1:0]            bar_length,
    output logic [hbc_pkg::CNT_W-1:0]           outside_total,
    output logic                                last_bin,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hbc_pkg::ADDR_W-1:0]          paddr,
    input  logic [hbc_pkg::DATA_W-1:0]          pwdata,
    output logic [hbc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import hbc_pkg::*;

    localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DIV_W  = (CNT_W + IDX_W > CNT_W + BW_W) ? CNT_W + IDX_W : CNT_W + BW_W;
    localparam int DCNT_W = $clog2(DIV_W);

    localparam logic [IDX_W-1:0]  LAST_BIN  = IDX_W'(NUM_BINS - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(DIV_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_LOAD
    } state_t;

    state_t                   state_reg;
    logic                     readout_reg;
    logic signed [SMP_W-1:0]  lo_limit_reg;
    logic signed [SMP_W-1:0]  hi_limit_reg;
    logic [BW_W-1:0]          bar_width_reg;
    logic [NUM_BINS-1:0]      valid_reg;
    logic [CNT_W-1:0]         peak_reg;
    logic [CNT_W-1:0]         outside_reg;
    logic [CNT_W-1:0]         off_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         bin_reg;
    logic [CNT_W-1:0]         mem_q_reg;
    logic [CNT_W-1:0]         div_rem_reg;
    logic [CNT_W-1:0]         div_den_reg;
    logic [DIV_W-1:0]         div_shift_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         bin_index_reg;
    logic [CNT_W-1:0]         bin_count_reg;
    logic [BW_W-1:0]          bar_length_reg;
    logic [CNT_W-1:0]         outside_total_reg;
    logic                     last_bin_reg;

    logic [CNT_W-1:0]         bin_mem [NUM_BINS];

    logic                     in_fire;
    logic                     cfg_write;
    logic                     out_load;
    logic                     outside;
    logic [CNT_W-1:0]         span;
    logic [CNT_W:0]           div_trial;
    logic                     div_ge;
    logic [CNT_W-1:0]         div_rem_next;
    logic [DIV_W-1:0]         div_shift_next;
    logic [IDX_W-1:0]         bin_next;
    logic [DIV_W-1:0]         prod_bin;
    logic [DIV_W-1:0]         prod_bar;
    logic [CNT_W-1:0]         cnt_cur;
    logic [CNT_W-1:0]         cnt_inc;
    logic [BW_W-1:0]          bar_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign out_load  = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    assign outside = (sample < lo_limit_reg) || (sample > hi_limit_reg);
    assign span    = CNT_W'(hi_limit_reg - lo_limit_reg);

    // one restoring divide step
    assign div_trial      = {div_rem_reg, div_shift_reg[DIV_W-1]};
    assign div_ge         = (div_trial >= {1'b0, div_den_reg});
    assign div_rem_next   = div_ge ? CNT_W'(div_trial - {1'b0, div_den_reg})
                                   : div_trial[CNT_W-1:0];
    assign div_shift_next = {div_shift_reg[DIV_W-2:0], div_ge};
    assign bin_next       = (div_shift_next > DIV_W'(LAST_BIN)) ? LAST_BIN
                                                                : div_shift_next[IDX_W-1:0];

    assign prod_bin = DIV_W'(off_reg) * DIV_W'(LAST_BIN);
    assign prod_bar = DIV_W'(cnt_reg) * DIV_W'(bar_width_reg);

    assign cnt_cur  = valid_reg[bin_reg] ? mem_q_reg : '0;
    assign cnt_inc  = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    assign bar_next = (peak_reg == '0) ? '0
                    : (|div_shift_reg[DIV_W-1:BW_W]) ? '1
                    : div_shift_reg[BW_W-1:0];

    always_comb
    begin
        case (paddr[3:2])
            REG_LOW:  prdata = {{(DATA_W-SMP_W){1'b0}}, lo_limit_reg};
            REG_HIGH: prdata = {{(DATA_W-SMP_W){1'b0}}, hi_limit_reg};
            REG_BAR:  prdata = {{(DATA_W-BW_W){1'b0}}, bar_width_reg};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            mem_q_reg <= bin_mem[bin_reg];
        end
        if (state_reg == ST_UPDATE && !readout_reg)
        begin
            bin_mem[bin_reg] <= cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            readout_reg       <= 1'b0;
            lo_limit_reg      <= LOW_RST;
            hi_limit_reg      <= HIGH_RST;
            bar_width_reg     <= BAR_RST;
            valid_reg         <= '0;
            peak_reg          <= '0;
            outside_reg       <= '0;
            off_reg           <= '0;
            cnt_reg           <= '0;
            bin_reg           <= '0;
            div_rem_reg       <= '0;
            div_den_reg       <= '0;
            div_shift_reg     <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            bin_index_reg     <= '0;
            bin_count_reg     <= '0;
            bar_length_reg    <= '0;
            outside_total_reg <= '0;
            last_bin_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_LOW:  lo_limit_reg   <= pwdata[SMP_W-1:0];
                    REG_HIGH: hi_limit_reg   <= pwdata[SMP_W-1:0];
                    REG_BAR:  bar_width_reg  <= pwdata[BW_W-1:0];
                    default:  ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (mode)
                            MODE_ADD:
                            begin
                                readout_reg <= 1'b0;
                                if (outside)
                                begin
                                    if (outside_reg != COUNT_MAX)
                                    begin
                                        outside_reg <= outside_reg + 1'b1;
                                    end
                                end
                                else if (span == '0)
                                begin
                                    // equal bounds land in the first bin
                                    bin_reg   <= '0;
                                    state_reg <= ST_READ;
                                end
                                else
                                begin
                                    off_reg     <= CNT_W'(sample - lo_limit_reg);
                                    div_den_reg <= span;
                                    state_reg   <= ST_MUL;
                                end
                            end
                            MODE_READ:
                            begin
                                readout_reg <= 1'b1;
                                bin_reg     <= '0;
                                state_reg   <= ST_READ;
                            end
                            MODE_CLEAR:
                            begin
                                valid_reg   <= '0;
                                peak_reg    <= '0;
                                outside_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL:
                begin
                    div_shift_reg <= readout_reg ? prod_bar : prod_bin;
                    if (readout_reg)
                    begin
                        div_den_reg <= peak_reg;
                    end
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    div_rem_reg   <= div_rem_next;
                    div_shift_reg <= div_shift_next;
                    div_cnt_reg   <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        if (readout_reg)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            bin_reg   <= bin_next;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (readout_reg)
                    begin
                        cnt_reg   <= cnt_cur;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        valid_reg[bin_reg] <= 1'b1;
                        if (cnt_inc > peak_reg)
                        begin
                            peak_reg <= cnt_inc;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_LOAD:
                begin
                    // wait for the output register to free up
                    if (out_load)
                    begin
                        bin_index_reg     <= bin_reg;
                        bin_count_reg     <= cnt_reg;
                        bar_length_reg    <= bar_next;
                        outside_total_reg <= outside_reg;
                        last_bin_reg      <= (bin_reg == LAST_BIN);
                        if (bin_reg == LAST_BIN)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            bin_reg   <= bin_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign bin_index     = IDX_OUT_W'(bin_index_reg);
    assign bin_count     = bin_count_reg;
    assign bar_length    = bar_length_reg;
    assign outside_total = outside_total_reg;
    assign last_bin      = last_bin_reg;

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mode == MODE_CLEAR |=> peak_reg == '0 && outside_reg == '0 && valid_reg == '0)
        else $error("counters not cleared");

    a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE && !readout_reg |=> peak_reg >= $past(cnt_inc))
        else $error("peak below updated bin count");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_bin_reg |-> bin_index_reg == LAST_BIN)
        else $error("last flag on wrong bin");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && div_cnt_reg == DIV_LAST
        |=> state_reg == ST_READ || state_reg == ST_LOAD)
        else $error("divider did not finish");

endmodule

// ===== verif/histogram_checker.sv =====
module histogram_checker #(
    parameter int NUM_BINS = hbc_pkg::NUM_BINS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [hbc_pkg::MODE_W-1:0]       mode,
    input  logic signed [hbc_pkg::SMP_W-1:0] sample,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [hbc_pkg::IDX_OUT_W-1:0]    bin_index,
    input  logic [hbc_pkg::CNT_W-1:0]        bin_count,
    input  logic [hbc_pkg::BW_W-1:0]         bar_length,
    input  logic [hbc_pkg::CNT_W-1:0]        outside_total,
    input  logic                             last_bin,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hbc_pkg::ADDR_W-1:0]       paddr,
    input  logic [hbc_pkg::DATA_W-1:0]       pwdata,
    input  logic                             pready,
    output int                               fail_count,
    output int                               pending
);
    import hbc_pkg::*;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] index;
        logic [CNT_W-1:0]     count;
        logic [BW_W-1:0]      bar;
        logic [CNT_W-1:0]     outside;
        logic                 last;
    } bin_report_t;

    logic signed [SMP_W-1:0] lo_limit;
    logic signed [SMP_W-1:0] hi_limit;
    logic [BW_W-1:0]         bar_width;
    logic [CNT_W-1:0]        bin_counts [NUM_BINS];
    logic [CNT_W-1:0]        peak_count;
    logic [CNT_W-1:0]        outside_count;
    bin_report_t             expected_reports [$];

    task automatic clear_counts();
        for (int i = 0; i < NUM_BINS; i++)
        begin
            bin_counts[i] = '0;
        end
        peak_count    = '0;
        outside_count = '0;
    endtask

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int          offset;
        int          span;
        int          idx;
        int          bar;
        bin_report_t rep;
        if (!rst_n)
        begin
            lo_limit   = LOW_RST;
            hi_limit   = HIGH_RST;
            bar_width  = BAR_RST;
            clear_counts();
            expected_reports.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected result for bin_index %0d", bin_index);
                    fail_count++;
                end
                else
                begin
                    rep = expected_reports.pop_front();
                    check_field("bin_index", rep.index, bin_index);
                    check_field("bin_count", rep.count, bin_count);
                    check_field("bar_length", rep.bar, bar_length);
                    check_field("outside_total", rep.outside, outside_total);
                    check_field("last_bin", rep.last, last_bin);
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_LOW:  lo_limit   = pwdata[SMP_W-1:0];
                    REG_HIGH: hi_limit   = pwdata[SMP_W-1:0];
                    REG_BAR:  bar_width  = pwdata[BW_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                case (mode)
                    MODE_ADD:
                    begin
                        if (sample < lo_limit || sample > hi_limit)
                        begin
                            if (outside_count != COUNT_MAX)
                                outside_count++;
                        end
                        else
                        begin
                            idx = 0;
                            if (hi_limit > lo_limit)
                            begin
                                offset = int'(sample) - int'(lo_limit);
                                span   = int'(hi_limit) - int'(lo_limit);
                                idx    = (offset * (NUM_BINS - 1)) / span;
                            end
                            if (idx >= NUM_BINS)
                                idx = NUM_BINS - 1;
                            if (bin_counts[idx] != COUNT_MAX)
                                bin_counts[idx]++;
                            if (bin_counts[idx] > peak_count)
                                peak_count = bin_counts[idx];
                        end
                    end
                    MODE_READ:
                    begin
                        for (int i = 0; i < NUM_BINS; i++)
                        begin
                            bar = 0;
                            if (peak_count != 0)
                            begin
                                bar = (int'(bin_counts[i]) * int'(bar_width)) / int'(peak_count);
                                if (bar > 255)
                                    bar = 255;
                            end
                            rep.index   = IDX_OUT_W'(i);
                            rep.count   = bin_counts[i];
                            rep.bar     = BW_W'(bar);
                            rep.outside = outside_count;
                            rep.last    = (i == NUM_BINS - 1);
                            expected_reports.push_back(rep);
                        end
                    end
                    MODE_CLEAR:
                        clear_counts();
                    default: ;
                endcase
            end

            pending <= expected_reports.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import hbc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_WAIT = 64;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [MODE_W-1:0]       mode;
    logic signed [SMP_W-1:0] sample;
    logic                    out_valid;
    logic                    out_ready;
    logic [IDX_OUT_W-1:0]    bin_index;
    logic [CNT_W-1:0]        bin_count;
    logic [BW_W-1:0]         bar_length;
    logic [CNT_W-1:0]        outside_total;
    logic                    last_bin;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int fail_count;
    int pending;
    int idle_odds = 0;
    int quiet_cycles = 0;

    histogram_bin_counter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .bin_index(bin_index), .bin_count(bin_count), .bar_length(bar_length),
        .outside_total(outside_total), .last_bin(last_bin),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    histogram_checker hist_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .bin_index(bin_index), .bin_count(bin_count), .bar_length(bar_length),
        .outside_total(outside_total), .last_bin(last_bin),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_gap();
        if (int'($urandom_range(0, 99)) < idle_odds)
            return $urandom_range(0, 7);
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin : result_sink
        int gap;
        out_ready <= 1'b0;
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [SMP_W-1:0] s);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // pending is a registered value, so wait_results waits on the clock before it reads pending
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int lo, input int hi, input int bw);
        wait_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        write_reg(REG_LOW, DATA_W'(lo));
        write_reg(REG_HIGH, DATA_W'(hi));
        write_reg(REG_BAR, DATA_W'(bw));
    endtask

    initial
    begin : stimulus
        int lo;
        int hi;
        int r;
        logic [MODE_W-1:0] m;
        logic [SMP_W-1:0]  s;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        mode     <= MODE_ADD;
        sample   <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bounds, empty store first
        idle_odds = 40;
        send_request(MODE_READ, '0);
        send_request(MODE_ADD, 16'sd0);
        send_request(MODE_ADD, 16'sd25344);
        send_request(MODE_ADD, -16'sd1);
        send_request(MODE_ADD, 16'sd25345);
        send_request(MODE_ADD, 16'h8000);
        send_request(MODE_ADD, 16'h7fff);
        send_request(MODE_ADD, 16'sd12672);
        send_request(MODE_UNUSED, 16'($urandom));
        send_request(MODE_READ, '0);
        send_request(MODE_CLEAR, 16'($urandom));
        send_request(MODE_READ, '0);

        // widest span and widest bar
        configure(-32768, 32767, 255);
        send_request(MODE_ADD, 16'h8000);
        send_request(MODE_ADD, 16'h7fff);
        send_request(MODE_ADD, 16'sd0);
        send_request(MODE_ADD, 16'sd0);
        send_request(MODE_READ, '0);

        // equal bounds
        configure(100, 100, 1);
        send_request(MODE_ADD, 16'sd100);
        send_request(MODE_ADD, 16'sd99);
        send_request(MODE_ADD, 16'sd101);
        send_request(MODE_READ, '0);

        // inverted bounds
        configure(1000, -1000, 7);
        send_request(MODE_ADD, 16'sd0);
        send_request(MODE_ADD, 16'sd1000);
        send_request(MODE_ADD, -16'sd1000);
        send_request(MODE_READ, '0);

        // a burst of negative samples below a narrow window
        configure(0, 100, 200);
        idle_odds = 5;
        repeat (20) send_request(MODE_ADD, {1'b1, 15'($urandom)});
        send_request(MODE_ADD, 16'sd50);
        send_request(MODE_READ, '0);
        send_request(MODE_CLEAR, '0);

        for (int p = 0; p < 5; p++)
        begin
            r  = $urandom_range(0, 5);
            lo = int'($urandom_range(0, 65535)) - 32768;
            if (r == 0)
                hi = int'($urandom_range(0, 65535)) - 32768;
            else if (r == 1)
            begin
                lo = -32768;
                hi = 32767;
            end
            else if (r == 2)
                hi = lo;
            else
            begin
                hi = lo + int'($urandom_range(1, (r == 3) ? 200 : 20000));
                if (hi > 32767)
                    hi = 32767;
            end
            configure(lo, hi, $urandom_range(1, 255));
            idle_odds = (p == 0) ? 0 : $urandom_range(20, 90);
            for (int n = 0; n < 36; n++)
            begin
                if (n == 18)
                    wait_results();
                r = $urandom_range(0, 99);
                m = (r < 80) ? MODE_ADD : (r < 88) ? MODE_READ :
                    (r < 94) ? MODE_CLEAR : MODE_UNUSED;
                r = $urandom_range(0, 99);
                if (r < 15 || hi < lo)
                    s = 16'($urandom);
                else if (r < 20)
                    s = 16'(lo - 1);
                else if (r < 25)
                    s = 16'(hi + 1);
                else
                    s = 16'(lo + int'($urandom_range(0, hi - lo)));
                send_request(m, s);
            end
            send_request(MODE_READ, '0);
        end

        wait_results();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== histogram_bin_counter.f =====
hw/rtl/hbc_pkg.sv
hw/rtl/histogram_bin_counter.sv
verif/histogram_checker.sv
verif/testbench.sv
